FILE: design/bpat_pkg.sv
// bpat_pkg: shared constants, codes and types of the banked page address translator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bpat_pkg;

  localparam int LOGICAL_PAGE_BYTES = 16384;
  localparam int LOGICAL_PAGES      = 4;
  localparam int PHYSICAL_PAGES     = 32;
  localparam int STORE_BYTES        = 131072;

  localparam int ADDR_W   = 17;
  localparam int DATA_W   = 8;
  localparam int PAGE_W   = 5;
  localparam int SLOT_W   = 2;
  localparam int OFF_W    = 17;
  localparam int SIZE_W   = 15;
  localparam int STORE_AW = $clog2(STORE_BYTES);
  localparam int DIVD_W   = $clog2(LOGICAL_PAGE_BYTES);
  localparam int SLOT_SEL = $clog2(LOGICAL_PAGES);
  localparam int PIDX_W   = $clog2(PHYSICAL_PAGES);
  localparam int CNT_W    = $clog2(DIVD_W);

  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_WRITE     = 3'd1,
    OP_RAW_READ  = 3'd2,
    OP_RAW_WRITE = 3'd3,
    OP_MAP       = 3'd4,
    OP_DEFINE    = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_DIV,
    S_MEM,
    S_RDWAIT,
    S_RESP
  } fsm_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic [DATA_W-1:0]   wdata;
  } mem_req_t;

endpackage
`default_nettype wire

FILE: design/bpat_divider.sv
// bpat_divider: restoring remainder unit, one dividend bit per cycle
// depends on bpat_pkg
`timescale 1ns / 1ps
`default_nettype none
module bpat_divider
  import bpat_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [DIVD_W-1:0] dvd_r, dvd_nxt;
  logic [SIZE_W-1:0] dsr_r, dsr_nxt;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  always_comb begin
    trial    = {rem_r, dvd_r[DIVD_W-1]};
    diff     = trial - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVD_W - 1);
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, dsr_r}) ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
      dvd_nxt = {dvd_r[DIVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[DIVD_W-1:0];

endmodule
`default_nettype wire

FILE: design/bpat_store.sv
// bpat_store: byte memory, one write or read per cycle, registered read data
// depends on bpat_pkg
`timescale 1ns / 1ps
`default_nettype none
module bpat_store
  import bpat_pkg::*;
(
  input  wire logic        clk,
  input  wire mem_req_t    req,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [STORE_BYTES];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata_r <= mem[req.addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: design/bpat_ctrl.sv
// bpat_ctrl: sequencer, slot map and page descriptor table
// depends on bpat_pkg; drives bpat_divider and bpat_store
`timescale 1ns / 1ps
`default_nettype none
module bpat_ctrl
  import bpat_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        in_opcode,
  input  wire logic [ADDR_W-1:0] in_address,
  input  wire logic [DATA_W-1:0] in_write_data,
  input  wire logic [PAGE_W-1:0] in_page_index,
  input  wire logic              in_direct,
  input  wire logic [SLOT_W-1:0] in_map_slot,
  input  wire logic [OFF_W-1:0]  in_page_offset,
  input  wire logic [SIZE_W-1:0] in_page_size,
  output logic                   out_valid,
  output logic [DATA_W-1:0]      out_read_data,
  output logic [1:0]             out_status,
  output div_req_t               div_req,
  input  wire div_rsp_t          div_rsp,
  output mem_req_t               mem_req,
  input  wire logic [DATA_W-1:0] mem_rdata
);

  fsm_t              state_r, state_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [DATA_W-1:0] wdata_r, wdata_nxt;
  logic [PAGE_W-1:0] pidx_r, pidx_nxt;
  logic              direct_r, direct_nxt;
  logic [SLOT_W-1:0] mslot_r, mslot_nxt;
  logic [OFF_W-1:0]  poff_r, poff_nxt;
  logic [SIZE_W-1:0] psize_r, psize_nxt;
  logic [OFF_W-1:0]  base_r, base_nxt;
  logic [STORE_AW-1:0] phys_r, phys_nxt;
  logic [DATA_W-1:0] rdata_r, rdata_nxt;
  status_t           status_r, status_nxt;

  logic [PAGE_W-1:0] slot_map_r [LOGICAL_PAGES];
  logic [OFF_W-1:0]  offsets_r [PHYSICAL_PAGES];
  logic [SIZE_W-1:0] sizes_r [PHYSICAL_PAGES];

  logic              map_we;
  logic              def_we;
  logic [PAGE_W-1:0] pg;
  logic              paged;
  logic [SIZE_W-1:0] pg_size;
  logic [OFF_W-1:0]  pg_off;
  logic [OFF_W:0]    def_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_OK;
      for (int i = 0; i < LOGICAL_PAGES; i++) begin
        slot_map_r[i] <= '0;
      end
      for (int i = 0; i < PHYSICAL_PAGES; i++) begin
        offsets_r[i] <= '0;
        sizes_r[i]   <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      if (map_we) begin
        slot_map_r[mslot_r[SLOT_SEL-1:0]] <= pidx_r;
      end
      if (def_we) begin
        offsets_r[pidx_r[PIDX_W-1:0]] <= poff_r;
        sizes_r[pidx_r[PIDX_W-1:0]]   <= psize_r;
      end
    end
    op_r     <= op_nxt;
    addr_r   <= addr_nxt;
    wdata_r  <= wdata_nxt;
    pidx_r   <= pidx_nxt;
    direct_r <= direct_nxt;
    mslot_r  <= mslot_nxt;
    poff_r   <= poff_nxt;
    psize_r  <= psize_nxt;
    base_r   <= base_nxt;
    phys_r   <= phys_nxt;
    rdata_r  <= rdata_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    addr_nxt   = addr_r;
    wdata_nxt  = wdata_r;
    pidx_nxt   = pidx_r;
    direct_nxt = direct_r;
    mslot_nxt  = mslot_r;
    poff_nxt   = poff_r;
    psize_nxt  = psize_r;
    base_nxt   = base_r;
    phys_nxt   = phys_r;
    rdata_nxt  = rdata_r;
    status_nxt = status_r;
    map_we     = 1'b0;
    def_we     = 1'b0;
    div_req    = '0;
    mem_req    = '0;
    mem_req.addr  = phys_r;
    mem_req.wdata = wdata_r;
    div_req.dividend = addr_r[DIVD_W-1:0];

    paged = 1'b0;
    pg    = pidx_r;
    if (op_r == OP_READ || op_r == OP_WRITE) begin
      paged = 1'b1;
      pg    = slot_map_r[addr_r[DIVD_W +: SLOT_SEL]];
    end else if ((op_r == OP_RAW_READ || op_r == OP_RAW_WRITE) && !direct_r) begin
      paged = 1'b1;
    end
    pg_size = sizes_r[pg[PIDX_W-1:0]];
    pg_off  = offsets_r[pg[PIDX_W-1:0]];
    div_req.divisor = pg_size;
    def_end = {1'b0, poff_r} + (OFF_W + 1)'(psize_r);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = in_opcode;
          addr_nxt   = in_address;
          wdata_nxt  = in_write_data;
          pidx_nxt   = in_page_index;
          direct_nxt = in_direct;
          mslot_nxt  = in_map_slot;
          poff_nxt   = in_page_offset;
          psize_nxt  = in_page_size;
          rdata_nxt  = '0;
          status_nxt = ST_OK;
          state_nxt  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_nxt = S_RESP;
        if (paged) begin
          if (32'(pg) >= PHYSICAL_PAGES) begin
            status_nxt = ST_RANGE;
          end else if (pg_size == '0) begin
            status_nxt = ST_ZERO;
          end else begin
            div_req.start = 1'b1;
            base_nxt      = pg_off;
            state_nxt     = S_DIV;
          end
        end else if (op_r == OP_RAW_READ || op_r == OP_RAW_WRITE) begin
          phys_nxt  = addr_r[STORE_AW-1:0];
          state_nxt = S_MEM;
        end else if (op_r == OP_MAP) begin
          if (32'(mslot_r) >= LOGICAL_PAGES || 32'(pidx_r) >= PHYSICAL_PAGES) begin
            status_nxt = ST_RANGE;
          end else begin
            map_we = 1'b1;
          end
        end else if (op_r == OP_DEFINE) begin
          if (32'(pidx_r) >= PHYSICAL_PAGES || 32'(psize_r) > LOGICAL_PAGE_BYTES ||
              32'(def_end) > STORE_BYTES) begin
            status_nxt = ST_RANGE;
          end else if (psize_r == '0) begin
            status_nxt = ST_ZERO;
          end else begin
            def_we = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          phys_nxt  = STORE_AW'(base_r + OFF_W'(div_rsp.rem));
          state_nxt = S_MEM;
        end
      end
      S_MEM: begin
        if (op_r == OP_WRITE || op_r == OP_RAW_WRITE) begin
          mem_req.we = 1'b1;
          state_nxt  = S_RESP;
        end else begin
          state_nxt = S_RDWAIT;
        end
      end
      S_RDWAIT: begin
        rdata_nxt = mem_rdata;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = (state_r == S_RESP);
  assign out_read_data = rdata_r;
  assign out_status    = status_r;

endmodule
`default_nettype wire

FILE: design/banked_page_address_translator.sv
// banked_page_address_translator: top level of the bank-switching memory unit
// depends on bpat_pkg, bpat_ctrl, bpat_divider, bpat_store
//
// usage:
//   a command beat is taken at the clock edge where start is high and busy is
//   low; the in_ ports carry opcode, address, write data and page fields
//   every command gives exactly one result beat: out_valid is high for one
//   cycle with out_read_data and out_status, and busy drops the cycle after
// path from the accepting edge to the result cycle, by state:
//   map, define, unused opcodes and translation errors: lookup, result
//   direct raw write: lookup, memory, result; direct raw read adds a read wait
//   paged write and read add a divide step before memory; the page-size
//   remainder runs in the divider at one address bit per cycle
// only one command is in flight: no new command is taken until busy drops
// reset clears the slot map and descriptor table (all pages size zero);
// the byte memory is not cleared and needs no clearing pass
// the receiver cannot stall: a result is shown for one cycle only
`timescale 1ns / 1ps
`default_nettype none
module banked_page_address_translator
  import bpat_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        in_opcode,
  input  wire logic [ADDR_W-1:0] in_address,
  input  wire logic [DATA_W-1:0] in_write_data,
  input  wire logic [PAGE_W-1:0] in_page_index,
  input  wire logic              in_direct,
  input  wire logic [SLOT_W-1:0] in_map_slot,
  input  wire logic [OFF_W-1:0]  in_page_offset,
  input  wire logic [SIZE_W-1:0] in_page_size,
  output logic                   out_valid,
  output logic [DATA_W-1:0]      out_read_data,
  output logic [1:0]             out_status
);

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;

  bpat_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_address     (in_address),
    .in_write_data  (in_write_data),
    .in_page_index  (in_page_index),
    .in_direct      (in_direct),
    .in_map_slot    (in_map_slot),
    .in_page_offset (in_page_offset),
    .in_page_size   (in_page_size),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data),
    .out_status     (out_status),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata)
  );

  bpat_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  bpat_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

FILE: design/bpat_checker.sv
// bpat_checker: port-level checks of the translator, bound to the top level
// depends on bpat_pkg and banked_page_address_translator
`timescale 1ns / 1ps
`default_nettype none
module bpat_checker
  import bpat_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [DATA_W-1:0] out_read_data,
  input wire logic [1:0]        out_status
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_resp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy ##1 !busy)
    else $error("result beat outside a command");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result held longer than one cycle");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_ZERO ||
                   out_status == ST_RANGE))
    else $error("bad status code");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_read_data == '0)
    else $error("error beat carries read data");

endmodule

bind banked_page_address_translator bpat_checker u_bpat_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_read_data (out_read_data),
  .out_status    (out_status)
);
`default_nettype wire
